@@ hw/rtl/brb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths and operation codes of the byte ring buffer engine.
// ----------------------------------------------------------------------------
package brb_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 10;
  localparam int CNT_W  = 10;
  localparam int OP_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE     = 3'd0,
    OP_DEQUEUE   = 3'd1,
    OP_PEEK      = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_ADV_WRITE = 3'd4,
    OP_ADV_READ  = 3'd5,
    OP_STATUS    = 3'd6
  } op_t;

endpackage

@@ hw/rtl/brb_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_store
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brb_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [brb_pkg::BYTE_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [brb_pkg::BYTE_W-1:0] rdata
);

  logic [brb_pkg::BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/brb_fill.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_fill
// Fill figures from the pointers and the held-byte count.
// ----------------------------------------------------------------------------
module brb_fill #(
  parameter int CAPACITY = 1023,
  parameter int PW       = 10
) (
  input  logic [PW-1:0]             rp,
  input  logic [PW-1:0]             wp,
  input  logic [PW-1:0]             used,
  output logic [brb_pkg::CNT_W-1:0] used_count,
  output logic [brb_pkg::CNT_W-1:0] free_count,
  output logic [brb_pkg::CNT_W-1:0] contiguous_free,
  output logic [brb_pkg::CNT_W-1:0] contiguous_used
);

  localparam int XW = (PW > brb_pkg::CNT_W) ? PW : brb_pkg::CNT_W;

  logic [XW:0] rp_x;
  logic [XW:0] wp_x;
  logic [XW:0] used_x;
  logic [XW:0] free_x;
  logic [XW:0] cfree_x;
  logic [XW:0] cused_x;

  always_comb begin
    rp_x   = (XW+1)'(rp);
    wp_x   = (XW+1)'(wp);
    used_x = (XW+1)'(used);
    free_x = (XW+1)'(CAPACITY) - used_x;
    if (wp_x >= rp_x) begin
      if (rp_x == '0) begin
        cfree_x = (XW+1)'(CAPACITY) - wp_x;
      end else begin
        cfree_x = (XW+1)'(CAPACITY + 1) - wp_x;
      end
    end else begin
      cfree_x = rp_x - wp_x - (XW+1)'(1);
    end
    if (rp_x <= wp_x) begin
      cused_x = wp_x - rp_x;
    end else begin
      cused_x = (XW+1)'(CAPACITY + 1) - rp_x;
    end
  end

  assign used_count      = used_x[brb_pkg::CNT_W-1:0];
  assign free_count      = free_x[brb_pkg::CNT_W-1:0];
  assign contiguous_free = cfree_x[brb_pkg::CNT_W-1:0];
  assign contiguous_used = cused_x[brb_pkg::CNT_W-1:0];

endmodule

@@ hw/rtl/brb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ctrl
// Pointer and run bookkeeping, burst read sequencer and result register.
// ----------------------------------------------------------------------------
module brb_ctrl #(
  parameter int CAPACITY  = 1023,
  parameter int MAX_BURST = 64,
  parameter int PW        = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [brb_pkg::OP_W-1:0]   opcode,
  input  logic [brb_pkg::LEN_W-1:0]  length,
  input  logic [brb_pkg::BYTE_W-1:0] data_byte,
  input  logic                       run_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brb_pkg::BYTE_W-1:0] out_byte,
  output logic                       last,
  output logic                       status,
  output logic [PW-1:0]              rp,
  output logic [PW-1:0]              wp,
  output logic [PW-1:0]              used,
  output logic                       mem_we,
  output logic [PW-1:0]              mem_waddr,
  output logic [brb_pkg::BYTE_W-1:0] mem_wdata,
  output logic                       mem_re,
  output logic [PW-1:0]              mem_raddr,
  input  logic [brb_pkg::BYTE_W-1:0] mem_rdata
);

  localparam int XW = (PW > brb_pkg::LEN_W) ? PW : brb_pkg::LEN_W;
  localparam int BW = $clog2(MAX_BURST + 1);

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_t;

  state_t                     state;
  logic [PW-1:0]              rp_next;
  logic [PW-1:0]              wp_next;
  logic [PW-1:0]              used_next;
  logic [brb_pkg::LEN_W-1:0]  run_rem;
  logic [brb_pkg::LEN_W-1:0]  run_rem_next;
  logic                       run_acc;
  logic                       run_acc_next;
  logic [PW-1:0]              rd_addr;
  logic [BW-1:0]              rd_left;
  logic                       rd_pend;

  logic                       out_free;
  logic                       accept;
  logic                       load;
  logic                       issue;
  logic                       single;
  logic                       go_burst;
  logic                       st;
  logic [XW-1:0]              len_x;
  logic [XW-1:0]              used_x;
  logic [XW-1:0]              free_x;
  logic [brb_pkg::LEN_W-1:0]  rem_base;
  logic [brb_pkg::LEN_W-1:0]  rem_dec;
  logic                       acc_base;
  logic                       acc_tmp;
  logic                       burst_ok;
  brb_pkg::op_t               op;

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] ptr, input logic [XW-1:0] inc);
    logic [XW:0] sum;
    sum = (XW+1)'(ptr) + (XW+1)'(inc);
    if (sum >= (XW+1)'(CAPACITY + 1)) begin
      sum = sum - (XW+1)'(CAPACITY + 1);
    end
    return sum[PW-1:0];
  endfunction

  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign load      = (state == S_BURST) && rd_pend && out_free;
  assign issue     = (state == S_BURST) && (rd_left != '0) && (!rd_pend || load);
  assign mem_re    = issue;
  assign mem_raddr = rd_addr;
  assign mem_waddr = wp;
  assign mem_wdata = data_byte;

  assign op       = brb_pkg::op_t'(opcode);
  assign len_x    = XW'(length);
  assign used_x   = XW'(used);
  assign free_x   = XW'(CAPACITY) - used_x;
  assign burst_ok = (length != '0) && (length <= brb_pkg::LEN_W'(MAX_BURST)) && (len_x <= used_x);

  always_comb begin
    rp_next      = rp;
    wp_next      = wp;
    used_next    = used;
    run_rem_next = run_rem;
    run_acc_next = run_acc;
    st           = 1'b0;
    single       = 1'b1;
    go_burst     = 1'b0;
    mem_we       = 1'b0;
    rem_base     = run_rem;
    acc_base     = run_acc;
    rem_dec      = '0;
    acc_tmp      = 1'b0;
    if (accept) begin
      unique case (op)
        brb_pkg::OP_WRITE: begin
          if (run_start) begin
            rem_base = length;
            acc_base = (length != '0) && (len_x <= free_x);
          end
          if (!run_start && (run_rem == '0)) begin
            st = 1'b1;
          end else begin
            rem_dec = (rem_base != '0) ? rem_base - brb_pkg::LEN_W'(1) : '0;
            acc_tmp = acc_base;
            if (!acc_base) begin
              st = 1'b1;
            end else if (free_x == '0) begin
              st      = 1'b1;
              acc_tmp = 1'b0;
            end else begin
              mem_we    = 1'b1;
              wp_next   = wrap_add(wp, XW'(1));
              used_next = used + PW'(1);
            end
            run_rem_next = rem_dec;
            run_acc_next = acc_tmp && (rem_dec != '0);
          end
        end
        brb_pkg::OP_DEQUEUE: begin
          if (!burst_ok) begin
            st = 1'b1;
          end else begin
            single    = 1'b0;
            go_burst  = 1'b1;
            rp_next   = wrap_add(rp, len_x);
            used_next = PW'(used_x - len_x);
          end
        end
        brb_pkg::OP_PEEK: begin
          if (!burst_ok) begin
            st = 1'b1;
          end else begin
            single   = 1'b0;
            go_burst = 1'b1;
          end
        end
        brb_pkg::OP_CLEAR: begin
          rp_next   = wp;
          used_next = '0;
        end
        brb_pkg::OP_ADV_WRITE: begin
          if ((length == '0) || (len_x > free_x)) begin
            st = 1'b1;
          end else begin
            wp_next   = wrap_add(wp, len_x);
            used_next = PW'(used_x + len_x);
          end
        end
        brb_pkg::OP_ADV_READ: begin
          if ((length == '0) || (len_x > used_x)) begin
            st = 1'b1;
          end else begin
            rp_next   = wrap_add(rp, len_x);
            used_next = PW'(used_x - len_x);
          end
        end
        brb_pkg::OP_STATUS: begin
          st = 1'b0;
        end
        default: begin
          st = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rp        <= '0;
      wp        <= '0;
      used      <= '0;
      run_rem   <= '0;
      run_acc   <= 1'b0;
      rd_left   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rp      <= rp_next;
      wp      <= wp_next;
      used    <= used_next;
      run_rem <= run_rem_next;
      run_acc <= run_acc_next;
      unique case (state)
        S_IDLE: begin
          if (accept && go_burst) begin
            state   <= S_BURST;
            rd_addr <= rp;
            rd_left <= BW'(length);
          end
        end
        S_BURST: begin
          if (issue) begin
            rd_addr <= wrap_add(rd_addr, XW'(1));
            rd_left <= rd_left - BW'(1);
          end
          rd_pend <= issue || (rd_pend && !load);
          if (load && (rd_left == '0)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (accept && single) begin
        out_valid <= 1'b1;
        out_byte  <= '0;
        last      <= 1'b1;
        status    <= st;
      end else if (load) begin
        out_valid <= 1'b1;
        out_byte  <= mem_rdata;
        last      <= (rd_left == '0);
        status    <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/byte_ring_buffer_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer_engine
// Circular byte FIFO with burst write runs, dequeue, peek, pointer advance,
// clear and status, kept in a single-port-pair byte store.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    opcode, length, data_byte, run_start
//   out      out_valid/out_ready  out_byte, last, status, used_count,
//                                 free_count, contiguous_free, contiguous_used
//
// A new write, clear, advance or status item is taken every cycle while the
// result register drains and no dequeue or peek burst is in progress.
// A dequeue or peek of n bytes gives n results, reading the store once per cycle
// while out is not stalled, with the registered store read ahead of each byte.
// Reset clears the pointers and run state; the store contents are not cleared.
// A stall on out holds the result register and, during a burst, the store read.
// ----------------------------------------------------------------------------
module byte_ring_buffer_engine #(
  parameter int CAPACITY  = 1023,
  parameter int MAX_BURST = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [brb_pkg::OP_W-1:0]   opcode,
  input  logic [brb_pkg::LEN_W-1:0]  length,
  input  logic [brb_pkg::BYTE_W-1:0] data_byte,
  input  logic                       run_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [brb_pkg::BYTE_W-1:0] out_byte,
  output logic                       last,
  output logic                       status,
  output logic [brb_pkg::CNT_W-1:0]  used_count,
  output logic [brb_pkg::CNT_W-1:0]  free_count,
  output logic [brb_pkg::CNT_W-1:0]  contiguous_free,
  output logic [brb_pkg::CNT_W-1:0]  contiguous_used
);

  localparam int PW = $clog2(CAPACITY + 1);

  logic [PW-1:0]              rp;
  logic [PW-1:0]              wp;
  logic [PW-1:0]              used;
  logic                       mem_we;
  logic [PW-1:0]              mem_waddr;
  logic [brb_pkg::BYTE_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [PW-1:0]              mem_raddr;
  logic [brb_pkg::BYTE_W-1:0] mem_rdata;

  brb_ctrl #(
    .CAPACITY (CAPACITY),
    .MAX_BURST(MAX_BURST),
    .PW       (PW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .length   (length),
    .data_byte(data_byte),
    .run_start(run_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .last     (last),
    .status   (status),
    .rp       (rp),
    .wp       (wp),
    .used     (used),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  brb_store #(
    .DEPTH(CAPACITY + 1),
    .AW   (PW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  brb_fill #(
    .CAPACITY(CAPACITY),
    .PW      (PW)
  ) u_fill (
    .rp             (rp),
    .wp             (wp),
    .used           (used),
    .used_count     (used_count),
    .free_count     (free_count),
    .contiguous_free(contiguous_free),
    .contiguous_used(contiguous_used)
  );

endmodule

@@ hw/rtl/brb_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_check
// Port-level checks of the byte ring buffer engine, bound to the top level.
// ----------------------------------------------------------------------------
module brb_check #(
  parameter int CAPACITY = 1023
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic                       last,
  input logic                       status,
  input logic [brb_pkg::CNT_W-1:0]  used_count,
  input logic [brb_pkg::CNT_W-1:0]  free_count,
  input logic [brb_pkg::CNT_W-1:0]  contiguous_used
);

  logic [brb_pkg::CNT_W-1:0] fill_sum;

  assign fill_sum = used_count + free_count;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> (!out_valid || out_ready))
    else $error("input taken while result register is blocked");

  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last)
    else $error("rejected transaction with more than one result");

  a_fill_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_sum == brb_pkg::CNT_W'(CAPACITY)))
    else $error("used and free counts disagree with capacity");

  a_contig_used: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((CAPACITY > 1023) || (contiguous_used <= used_count)))
    else $error("contiguous used exceeds used count");

endmodule

bind byte_ring_buffer_engine brb_check #(.CAPACITY(CAPACITY)) u_brb_check (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .last           (last),
  .status         (status),
  .used_count     (used_count),
  .free_count     (free_count),
  .contiguous_used(contiguous_used)
);
